### hdl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, constants, types and helpers for the great-circle distance
// pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int FIX_BITS        = 30;
    localparam int CORDIC_STEPS    = 30;

    localparam int LAT_W       = 24;
    localparam int LON_W       = 25;
    localparam int RADIUS_W    = 16;
    localparam int ARC_W       = 18;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 24;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

    // Q2.30 trig values, CORDIC datapath widths
    localparam int TRIG_W     = 32;
    localparam int ROT_XW     = 33;
    localparam int CORDIC_ZW  = 33;
    localparam int VEC_XW     = 34;
    localparam int ATAN_W     = 32;

    localparam logic [ATAN_W-1:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [ATAN_W-1:0] ONE_Q30         = 32'd1073741824;

    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021688,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2
    };

    typedef logic signed [TRIG_W-1:0] t_q30;

    typedef struct packed {
        t_q30 s;
        t_q30 c;
    } t_sincos;

    // pipeline advance and the valid bit entering a unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    // clamp a CORDIC output to [-1, 1] in Q2.30
    function automatic t_q30 clamp_unit(input logic signed [ROT_XW-1:0] v);
        logic signed [ROT_XW-1:0] lim;
        lim = ROT_XW'(ONE_Q30);
        if (v > lim) begin
            return TRIG_W'(lim);
        end else if (v < -lim) begin
            return TRIG_W'(-lim);
        end
        return TRIG_W'(v);
    endfunction

endpackage

### hdl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Angle wrap and fold, degrees to radians, pipelined rotation CORDIC.
// ----------------------------------------------------------------------------
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int ANG_W = LAT_W,
    parameter int FRAC  = ANGLE_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_valid,
    output t_sincos                 o_sc
);

    localparam longint FULL    = longint'(360) << FRAC;
    localparam longint HALF    = longint'(180) << FRAC;
    localparam longint QUARTER = longint'(90) << FRAC;
    localparam int     W       = $clog2(FULL) + 2;
    localparam int     DEG_W   = 26;
    localparam int     PW      = W + DEG_W;
    localparam int     N       = CORDIC_STEPS;

    localparam logic signed [W-1:0]     C_FULL    = W'(FULL);
    localparam logic signed [W-1:0]     C_HALF    = W'(HALF);
    localparam logic signed [W-1:0]     C_QUARTER = W'(QUARTER);
    localparam logic signed [DEG_W-1:0] C_DEG     = 26'sd18740330;

    logic signed [W-1:0]  w_ext, n_a, r_a, n_b, r_b;
    logic                 r_a_v, r_b_v, n_b_neg, r_b_neg;
    logic signed [PW-1:0] w_prod;
    logic signed [CORDIC_ZW-1:0] r_cz0;
    logic                 r_c_v, r_c_neg;

    // wrap into [-180, 180)
    always_comb begin
        w_ext = W'(i_angle);
        if (w_ext >= C_HALF) begin
            n_a = w_ext - C_FULL;
        end else if (w_ext < -C_HALF) begin
            n_a = w_ext + C_FULL;
        end else begin
            n_a = w_ext;
        end
    end

    // fold into [-90, 90], sin and cos negated
    always_comb begin
        n_b     = r_a;
        n_b_neg = 1'b0;
        if (r_a > C_QUARTER) begin
            n_b     = r_a - C_HALF;
            n_b_neg = 1'b1;
        end else if (r_a < -C_QUARTER) begin
            n_b     = r_a + C_HALF;
            n_b_neg = 1'b1;
        end
    end

    assign w_prod = PW'(r_b) * PW'(C_DEG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_v <= i_ctl.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_b_neg <= n_b_neg;
            r_cz0   <= w_prod[FRAC+CORDIC_ZW-1:FRAC];
            r_c_neg <= r_b_neg;
        end
    end

    // rotation CORDIC, one iteration per stage
    logic signed [ROT_XW-1:0]    w_x [0:N-1];
    logic signed [ROT_XW-1:0]    w_y [0:N-1];
    logic signed [CORDIC_ZW-1:0] w_z [0:N-1];
    logic                        w_n [0:N-1];
    logic                        w_v [0:N-1];
    logic signed [ROT_XW-1:0]    r_x [1:N];
    logic signed [ROT_XW-1:0]    r_y [1:N];
    logic signed [CORDIC_ZW-1:0] r_z [1:N];
    logic                        r_n [1:N];
    logic                        r_v [1:N];

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [ROT_XW-1:0]    w_dx, w_dy;
        logic signed [CORDIC_ZW-1:0] w_at;

        if (i == 0) begin : g_first
            assign w_x[0] = ROT_XW'(CORDIC_GAIN_Q30);
            assign w_y[0] = '0;
            assign w_z[0] = r_cz0;
            assign w_n[0] = r_c_neg;
            assign w_v[0] = r_c_v;
        end else begin : g_next
            assign w_x[i] = r_x[i];
            assign w_y[i] = r_y[i];
            assign w_z[i] = r_z[i];
            assign w_n[i] = r_n[i];
            assign w_v[i] = r_v[i];
        end

        assign w_dx = w_y[i] >>> i;
        assign w_dy = w_x[i] >>> i;
        assign w_at = CORDIC_ZW'(ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[i+1] <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_n[i+1] <= w_n[i];
                if (!w_z[i][CORDIC_ZW-1]) begin
                    r_x[i+1] <= w_x[i] - w_dx;
                    r_y[i+1] <= w_y[i] + w_dy;
                    r_z[i+1] <= w_z[i] - w_at;
                end else begin
                    r_x[i+1] <= w_x[i] + w_dx;
                    r_y[i+1] <= w_y[i] - w_dy;
                    r_z[i+1] <= w_z[i] + w_at;
                end
            end
        end
    end

    t_q30 w_s, w_c;
    assign w_s = clamp_unit(r_y[N]);
    assign w_c = clamp_unit(r_x[N]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_sc.s <= r_n[N] ? -w_s : w_s;
            o_sc.c <= r_n[N] ? -w_c : w_c;
        end
    end

endmodule

### hdl/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined floor square root of (h << 30), one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic [FIX_BITS:0]   i_h,
    output logic                o_valid,
    output logic [FIX_BITS:0]   o_root
);

    localparam int STEPS = FIX_BITS + 1;
    localparam int VW    = 2 * FIX_BITS + 2;

    logic [VW-1:0] w_rem  [0:STEPS-1];
    logic [VW-1:0] w_root [0:STEPS-1];
    logic          w_v    [0:STEPS-1];
    logic [VW-1:0] r_rem  [1:STEPS];
    logic [VW-1:0] r_root [1:STEPS];
    logic          r_v    [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_bit
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (STEPS - 1 - k));
        logic [VW-1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem[0]  = VW'({i_h, FIX_BITS'(0)});
            assign w_root[0] = '0;
            assign w_v[0]    = i_ctl.valid;
        end else begin : g_next
            assign w_rem[k]  = r_rem[k];
            assign w_root[k] = r_root[k];
            assign w_v[k]    = r_v[k];
        end

        assign w_trial = w_root[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k+1] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (w_rem[k] >= w_trial) begin
                    r_rem[k+1]  <= w_rem[k] - w_trial;
                    r_root[k+1] <= (w_root[k] >> 1) + BIT;
                end else begin
                    r_rem[k+1]  <= w_rem[k];
                    r_root[k+1] <= w_root[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_root  = r_root[STEPS][FIX_BITS:0];

endmodule

### hdl/gcd_atan.sv
// ----------------------------------------------------------------------------
// gcd_atan
// Pipelined vectoring CORDIC: angle of (x, y), one iteration per stage.
// ----------------------------------------------------------------------------
module gcd_atan
    import gcd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_pipe_ctl                   i_ctl,
    input  logic [FIX_BITS:0]           i_y,
    input  logic [FIX_BITS:0]           i_x,
    output logic                        o_valid,
    output logic signed [CORDIC_ZW-1:0] o_theta
);

    localparam int N = CORDIC_STEPS;

    logic signed [VEC_XW-1:0]    w_x [0:N-1];
    logic signed [VEC_XW-1:0]    w_y [0:N-1];
    logic signed [CORDIC_ZW-1:0] w_z [0:N-1];
    logic                        w_v [0:N-1];
    logic signed [VEC_XW-1:0]    r_x [1:N];
    logic signed [VEC_XW-1:0]    r_y [1:N];
    logic signed [CORDIC_ZW-1:0] r_z [1:N];
    logic                        r_v [1:N];

    for (genvar i = 0; i < N; i++) begin : g_vec
        logic signed [VEC_XW-1:0]    w_dx, w_dy;
        logic signed [CORDIC_ZW-1:0] w_at;

        if (i == 0) begin : g_first
            assign w_x[0] = VEC_XW'(i_x);
            assign w_y[0] = VEC_XW'(i_y);
            assign w_z[0] = '0;
            assign w_v[0] = i_ctl.valid;
        end else begin : g_next
            assign w_x[i] = r_x[i];
            assign w_y[i] = r_y[i];
            assign w_z[i] = r_z[i];
            assign w_v[i] = r_v[i];
        end

        assign w_dx = w_y[i] >>> i;
        assign w_dy = w_x[i] >>> i;
        assign w_at = CORDIC_ZW'(ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[i+1] <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (w_y[i][VEC_XW-1]) begin
                    r_x[i+1] <= w_x[i] - w_dx;
                    r_y[i+1] <= w_y[i] + w_dy;
                    r_z[i+1] <= w_z[i] - w_at;
                end else begin
                    r_x[i+1] <= w_x[i] + w_dx;
                    r_y[i+1] <= w_y[i] - w_dy;
                    r_z[i+1] <= w_z[i] + w_at;
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_theta = r_z[N];

endmodule

### hdl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point pair per transaction: source and destination
//   latitude/longitude in signed degrees with 16 fraction bits.
//   m_axis returns one transaction per input: the central angle times the
//   sphere radius, truncated to an integer.
//   i_cfg_we/i_cfg_wdata load the radius; write it only while the pipe is
//   empty. Reset loads 6371.
// Timing:
//   The pipe runs from input acceptance to m_axis_tvalid through the diff
//   stage, the sin/cos units (wrap, fold, scale, 30 CORDIC iterations,
//   clamp), the haversine products, the square roots (one root bit per
//   stage), the arctangent CORDIC, and then the radius multiply and the
//   output register.
//   Throughput is one transaction per cycle while the output is not stalled.
// Reset / stall:
//   Synchronous reset empties the pipe. When the output register holds a
//   result that is not taken, the whole pipe holds and s_axis_tready drops;
//   nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config: sphere radius
    input  logic                   i_cfg_we,
    input  logic [RADIUS_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [23:0] source_latitude, [48:24] source_longitude,
    // [72:49] dest_latitude, [97:73] dest_longitude, [103:98] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [17:0] arc_distance, [23:18] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int DLAT_W = LAT_W + 1;
    localparam int DLON_W = LON_W + 1;
    localparam int HW     = FIX_BITS + 1;
    localparam int SUM_W  = TRIG_W + 1;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int THETA_W = FIX_BITS + 1;
    localparam int SCALE_W = THETA_W + RADIUS_W + 1;

    logic w_en;
    logic r_out_valid;
    logic [ARC_W-1:0] r_out_data;

    // whole pipe moves unless the output register is full and stalled
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // radius register
    logic [RADIUS_W-1:0] r_radius;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // input unpack
    logic signed [LAT_W-1:0] w_lat1, w_lat2;
    logic signed [LON_W-1:0] w_lon1, w_lon2;
    assign w_lat1 = s_axis_tdata[23:0];
    assign w_lon1 = s_axis_tdata[48:24];
    assign w_lat2 = s_axis_tdata[72:49];
    assign w_lon2 = s_axis_tdata[97:73];

    // stage 0: coordinate differences
    logic signed [LAT_W-1:0]  r0_lat1, r0_lat2;
    logic signed [DLAT_W-1:0] r0_dlat;
    logic signed [DLON_W-1:0] r0_dlon;
    logic                     r0_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_lat1 <= w_lat1;
            r0_lat2 <= w_lat2;
            r0_dlat <= DLAT_W'(w_lat1) - DLAT_W'(w_lat2);
            r0_dlon <= DLON_W'(w_lon1) - DLON_W'(w_lon2);
        end
    end

    t_pipe_ctl w_ctl0;
    assign w_ctl0 = '{en: w_en, valid: r0_v};

    // four sin/cos units; half angles use one extra fraction bit
    t_sincos w_sc_dlat, w_sc_dlon, w_sc_lat1, w_sc_lat2;
    logic    w_sc_v;

    gcd_sincos #(.ANG_W(DLAT_W), .FRAC(ANGLE_FRAC_BITS + 1)) u_sc_dlat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_angle (r0_dlat),
        .o_valid (w_sc_v),
        .o_sc    (w_sc_dlat)
    );

    gcd_sincos #(.ANG_W(DLON_W), .FRAC(ANGLE_FRAC_BITS + 1)) u_sc_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_angle (r0_dlon),
        .o_valid (),
        .o_sc    (w_sc_dlon)
    );

    gcd_sincos #(.ANG_W(LAT_W), .FRAC(ANGLE_FRAC_BITS)) u_sc_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_angle (r0_lat1),
        .o_valid (),
        .o_sc    (w_sc_lat1)
    );

    gcd_sincos #(.ANG_W(LAT_W), .FRAC(ANGLE_FRAC_BITS)) u_sc_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_angle (r0_lat2),
        .o_valid (),
        .o_sc    (w_sc_lat2)
    );

    // stage 1: sin^2(dlat/2), cos1*cos2, sin^2(dlon/2)
    logic signed [PROD_W-1:0] w_sa2, w_c12, w_sb2;
    t_q30 r1_sa2, r1_c12, r1_sb2;
    logic r1_v;

    assign w_sa2 = PROD_W'(w_sc_dlat.s) * PROD_W'(w_sc_dlat.s);
    assign w_c12 = PROD_W'(w_sc_lat1.c) * PROD_W'(w_sc_lat2.c);
    assign w_sb2 = PROD_W'(w_sc_dlon.s) * PROD_W'(w_sc_dlon.s);

    // stage 2: cos1*cos2*sin^2(dlon/2)
    logic signed [PROD_W-1:0] w_t;
    t_q30 r2_sa2, r2_t;
    logic r2_v;

    assign w_t = PROD_W'(r1_c12) * PROD_W'(r1_sb2);

    // stage 3: h clamped to [0, 1], and 1 - h
    logic signed [SUM_W-1:0] w_hsum;
    logic [HW-1:0] n_h, r3_h, r3_hc;
    logic r3_v;

    assign w_hsum = SUM_W'(r2_sa2) + SUM_W'(r2_t);
    always_comb begin
        if (w_hsum[SUM_W-1]) begin
            n_h = '0;
        end else if (w_hsum > SUM_W'(ONE_Q30)) begin
            n_h = HW'(ONE_Q30);
        end else begin
            n_h = HW'(w_hsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_sc_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sa2 <= w_sa2[FIX_BITS+TRIG_W-1:FIX_BITS];
            r1_c12 <= w_c12[FIX_BITS+TRIG_W-1:FIX_BITS];
            r1_sb2 <= w_sb2[FIX_BITS+TRIG_W-1:FIX_BITS];
            r2_sa2 <= r1_sa2;
            r2_t   <= w_t[FIX_BITS+TRIG_W-1:FIX_BITS];
            r3_h   <= n_h;
            r3_hc  <= HW'(ONE_Q30) - n_h;
        end
    end

    // square roots of h and 1 - h
    t_pipe_ctl w_ctl3;
    logic [HW-1:0] w_rs, w_rc;
    logic          w_rt_v;
    assign w_ctl3 = '{en: w_en, valid: r3_v};

    gcd_isqrt u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl3),
        .i_h     (r3_h),
        .o_valid (w_rt_v),
        .o_root  (w_rs)
    );

    gcd_isqrt u_sqrt_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl3),
        .i_h     (r3_hc),
        .o_valid (),
        .o_root  (w_rc)
    );

    // central half-angle = atan2(sqrt(h), sqrt(1 - h))
    t_pipe_ctl w_ctl_at;
    logic signed [CORDIC_ZW-1:0] w_theta;
    logic w_theta_v;
    assign w_ctl_at = '{en: w_en, valid: w_rt_v};

    gcd_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_at),
        .i_y     (w_rs),
        .i_x     (w_rc),
        .o_valid (w_theta_v),
        .o_theta (w_theta)
    );

    // stage 4: theta * 2 * radius; negative angle reads as zero
    logic [THETA_W-1:0] w_theta_pos;
    logic [SCALE_W-1:0] r4_prod;
    logic               r4_v;

    assign w_theta_pos = w_theta[CORDIC_ZW-1] ? '0 : w_theta[THETA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r4_v        <= w_theta_v;
            r_out_valid <= r4_v;
        end
    end

    // product is below 2^48, so the shifted value always fits 18 bits
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_prod    <= SCALE_W'(w_theta_pos) * SCALE_W'({r_radius, 1'b0});
            r_out_data <= r4_prod[FIX_BITS+ARC_W-1:FIX_BITS];
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_h_complement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> ((32'(r3_h) + 32'(r3_hc)) == ONE_Q30))
        else $error("h and 1-h do not sum to one");

    a_out_follows_stage4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r4_v) |=> m_axis_tvalid)
        else $error("result lost between scale and output stage");

endmodule
